@@ hdl/ilir_pkg.sv @@
package ilir_pkg;

  localparam int CAPACITY  = 16;
  localparam int WORD_W    = 32;
  localparam int IN_IDX_W  = 5;
  localparam int OUT_CNT_W = 5;
  localparam int IDX_W     = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W     = $clog2(CAPACITY + 1);
  localparam int WIDE_W    = (CNT_W > IN_IDX_W) ? CNT_W : IN_IDX_W;

  typedef enum logic [2:0] {
    OP_INSERT     = 3'd0,
    OP_REMOVE     = 3'd1,
    OP_PUSH_BACK  = 3'd2,
    OP_POP_BACK   = 3'd3,
    OP_PUSH_FRONT = 3'd4,
    OP_POP_FRONT  = 3'd5
  } op_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_RANGE = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_INS_RD,
    S_INS_WR,
    S_REM_RD0,
    S_REM_GET,
    S_REM_RD,
    S_REM_WR,
    S_DONE
  } state_e;

  typedef struct packed {
    logic                     we;
    logic [IDX_W-1:0]         waddr;
    logic signed [WORD_W-1:0] wdata;
    logic [IDX_W-1:0]         raddr;
  } mem_req_t;

  typedef struct packed {
    logic signed [WORD_W-1:0] value;
    status_e                  status;
    logic [CNT_W-1:0]         count;
  } result_t;

endpackage

@@ hdl/ilir_mem.sv @@
module ilir_mem
  import ilir_pkg::*;
(
  input  logic                     clk_i,
  input  mem_req_t                 req_i,
  output logic signed [WORD_W-1:0] rdata_o
);

  logic signed [WORD_W-1:0] mem [CAPACITY];
  logic signed [WORD_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
    rdata_q <= mem[req_i.raddr];
  end

  assign rdata_o = rdata_q;

endmodule

@@ hdl/ilir_ctrl.sv @@
module ilir_ctrl
  import ilir_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic [2:0]               op_i,
  input  logic [IN_IDX_W-1:0]      index_i,
  input  logic signed [WORD_W-1:0] value_in_i,
  output mem_req_t                 mem_req_o,
  input  logic signed [WORD_W-1:0] mem_rdata_i,
  output logic                     res_valid_o,
  input  logic                     res_ready_i,
  output result_t                  res_o
);

  state_e                   state_q, state_d;
  logic [CNT_W-1:0]         cnt_q, cnt_d;
  logic [CNT_W-1:0]         ptr_q, ptr_d;
  logic [CNT_W-1:0]         pos_q, pos_d;
  logic signed [WORD_W-1:0] val_q, val_d;
  logic signed [WORD_W-1:0] win_q, win_d;
  status_e                  st_q, st_d;

  logic [WIDE_W-1:0] pos_w;
  logic [WIDE_W-1:0] cnt_w;
  logic              is_ins;
  logic              is_rem;
  logic [CNT_W-1:0]  ptr_dec;
  logic [CNT_W-1:0]  ptr_inc;

  assign cnt_w   = WIDE_W'(cnt_q);
  assign ptr_dec = ptr_q - CNT_W'(1);
  assign ptr_inc = ptr_q + CNT_W'(1);

  always_comb begin
    pos_w  = '0;
    is_ins = 1'b0;
    is_rem = 1'b0;
    case (op_e'(op_i))
      OP_INSERT: begin
        pos_w  = WIDE_W'(index_i);
        is_ins = 1'b1;
      end
      OP_PUSH_BACK: begin
        pos_w  = cnt_w;
        is_ins = 1'b1;
      end
      OP_PUSH_FRONT: begin
        is_ins = 1'b1;
      end
      OP_REMOVE: begin
        pos_w  = WIDE_W'(index_i);
        is_rem = 1'b1;
      end
      OP_POP_BACK: begin
        pos_w  = cnt_w - WIDE_W'(1);
        is_rem = 1'b1;
      end
      OP_POP_FRONT: begin
        is_rem = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    ptr_d       = ptr_q;
    pos_d       = pos_q;
    val_d       = val_q;
    win_d       = win_q;
    st_d        = st_q;
    mem_req_o   = '0;
    res_valid_o = 1'b0;
    in_stall_o  = (state_q != S_IDLE);
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          val_d   = '0;
          st_d    = ST_OK;
          win_d   = value_in_i;
          pos_d   = pos_w[CNT_W-1:0];
          ptr_d   = cnt_q;
          state_d = S_DONE;
          if (is_ins) begin
            if (cnt_q == CNT_W'(CAPACITY)) begin
              st_d = ST_FULL;
            end else if (pos_w > cnt_w) begin
              st_d = ST_RANGE;
            end else begin
              state_d = S_INS_RD;
            end
          end else if (is_rem) begin
            if (cnt_q == '0) begin
              st_d = ST_EMPTY;
            end else if (pos_w >= cnt_w) begin
              st_d = ST_RANGE;
            end else begin
              state_d = S_REM_RD0;
            end
          end
        end
      end
      S_INS_RD: begin
        if (ptr_q > pos_q) begin
          mem_req_o.raddr = ptr_dec[IDX_W-1:0];
          state_d         = S_INS_WR;
        end else begin
          mem_req_o.we    = 1'b1;
          mem_req_o.waddr = pos_q[IDX_W-1:0];
          mem_req_o.wdata = win_q;
          cnt_d           = cnt_q + CNT_W'(1);
          state_d         = S_DONE;
        end
      end
      S_INS_WR: begin
        mem_req_o.we    = 1'b1;
        mem_req_o.waddr = ptr_q[IDX_W-1:0];
        mem_req_o.wdata = mem_rdata_i;
        ptr_d           = ptr_dec;
        state_d         = S_INS_RD;
      end
      S_REM_RD0: begin
        mem_req_o.raddr = pos_q[IDX_W-1:0];
        state_d         = S_REM_GET;
      end
      S_REM_GET: begin
        val_d   = mem_rdata_i;
        ptr_d   = pos_q;
        state_d = S_REM_RD;
      end
      S_REM_RD: begin
        if (ptr_inc < cnt_q) begin
          mem_req_o.raddr = ptr_inc[IDX_W-1:0];
          state_d         = S_REM_WR;
        end else begin
          cnt_d   = cnt_q - CNT_W'(1);
          state_d = S_DONE;
        end
      end
      S_REM_WR: begin
        mem_req_o.we    = 1'b1;
        mem_req_o.waddr = ptr_q[IDX_W-1:0];
        mem_req_o.wdata = mem_rdata_i;
        ptr_d           = ptr_inc;
        state_d         = S_REM_RD;
      end
      S_DONE: begin
        res_valid_o = 1'b1;
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ptr_q <= ptr_d;
    pos_q <= pos_d;
    val_q <= val_d;
    win_q <= win_d;
    st_q  <= st_d;
  end

  assign res_o.value  = val_q;
  assign res_o.status = st_q;
  assign res_o.count  = cnt_q;

endmodule

@@ hdl/indexed_list_insert_remove.sv @@
// Indexed list of signed 32-bit words, capacity CAPACITY (16) entries.
// Input channel: in_valid_i / in_stall_o carry op_i, index_i, value_in_i.
// Output channel: out_valid_o / out_stall_i carry value_out_o, status_o and
// count_out_o, one word per input word.
// Ops: insert at index, remove at index, push/pop back, push/pop front.
// Full, empty and out-of-range requests are refused, list left untouched.
// Entries are held in a single-port-write, registered-read RAM; a sequencer
// moves entries through it one at a time, a read then a write per entry.
// Steps from acceptance to out_valid_o (k = entries moved):
//   insert/push: shift k = count - position entries up, then write the word
//   remove/pop:  read the word, then shift k = count - position - 1 down
//   refused or undefined op: result set up directly, no RAM access
// in_stall_o is high from acceptance until the result leaves the sequencer
// for the output register, so the next word can enter in the cycle after that.
// A stalled result holds in the output register; a finished result behind
// it waits in the sequencer.
// Reset empties the list; entries are not cleared and need no clearing pass.
module indexed_list_insert_remove
  import ilir_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic [2:0]               op_i,
  input  logic [IN_IDX_W-1:0]      index_i,
  input  logic signed [WORD_W-1:0] value_in_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic signed [WORD_W-1:0] value_out_o,
  output logic [1:0]               status_o,
  output logic [OUT_CNT_W-1:0]     count_out_o
);

  mem_req_t                 mem_req;
  logic signed [WORD_W-1:0] mem_rdata;
  logic                     res_valid;
  logic                     res_ready;
  result_t                  res;

  logic                     out_valid_q;
  logic signed [WORD_W-1:0] out_value_q;
  logic [1:0]               out_status_q;
  logic [OUT_CNT_W-1:0]     out_count_q;
  logic [WIDE_W-1:0]        res_cnt_w;

  ilir_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .op_i        (op_i),
    .index_i     (index_i),
    .value_in_i  (value_in_i),
    .mem_req_o   (mem_req),
    .mem_rdata_i (mem_rdata),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res)
  );

  ilir_mem u_mem (
    .clk_i   (clk_i),
    .req_i   (mem_req),
    .rdata_o (mem_rdata)
  );

  assign res_ready = !out_valid_q || !out_stall_i;
  assign res_cnt_w = WIDE_W'(res.count);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      out_value_q  <= res.value;
      out_status_q <= res.status;
      out_count_q  <= res_cnt_w[OUT_CNT_W-1:0];
    end
  end

  assign out_valid_o = out_valid_q;
  assign value_out_o = out_value_q;
  assign status_o    = out_status_q;
  assign count_out_o = out_count_q;

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("sequencer ready right after accepting a word");

  a_refused_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o != ST_OK) |-> value_out_o == '0)
    else $error("refused request returned a non-zero word");

  a_empty_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == ST_EMPTY) |-> count_out_o == '0)
    else $error("empty status with non-zero count");

endmodule
